@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ndp_pkg.sv @@
// ----------------------------------------------------------------------------
// ndp_pkg
// Types, constants and helpers shared by the next digit permutation core.
// ----------------------------------------------------------------------------
package ndp_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int DIGIT_W    = 4;
  localparam int CNT_IN_W   = 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int STATUS_W   = 2;

  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef digit_t [MAX_DIGITS-1:0] digits_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [MAX_DIGITS-1:0] lane_vec_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_REPEAT = 2'd1,
    ST_LAST   = 2'd2
  } status_t;

  // Per-position findings of the scan lanes.
  typedef struct packed {
    logic asc;
    logic rep;
  } scan_flags_t;

  // Outcome of the merge across lanes.
  typedef struct packed {
    status_t status;
    idx_t    j;
  } merge_t;

  typedef struct packed {
    logic found;
    idx_t idx;
  } pick_t;

  // Highest set position of a lane vector.
  function automatic pick_t last_set(lane_vec_t v);
    pick_t r;
    r = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/ndp_in_if.sv @@
// ----------------------------------------------------------------------------
// ndp_in_if
// Input channel: digit string and count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ndp_in_if import ndp_pkg::*; ();

  logic                valid;
  logic                ready;
  digit_t              digit_0;
  digit_t              digit_1;
  digit_t              digit_2;
  digit_t              digit_3;
  digit_t              digit_4;
  digit_t              digit_5;
  digit_t              digit_6;
  digit_t              digit_7;
  logic [CNT_IN_W-1:0] digit_count;

  modport source (
    output valid, digit_0, digit_1, digit_2, digit_3,
           digit_4, digit_5, digit_6, digit_7, digit_count,
    input  ready
  );

  modport sink (
    input  valid, digit_0, digit_1, digit_2, digit_3,
           digit_4, digit_5, digit_6, digit_7, digit_count,
    output ready
  );

endinterface

@@ rtl/ndp_out_if.sv @@
// ----------------------------------------------------------------------------
// ndp_out_if
// Output channel: next permutation digits and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ndp_out_if import ndp_pkg::*; ();

  logic                valid;
  logic                ready;
  digit_t              next_0;
  digit_t              next_1;
  digit_t              next_2;
  digit_t              next_3;
  digit_t              next_4;
  digit_t              next_5;
  digit_t              next_6;
  digit_t              next_7;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, next_0, next_1, next_2, next_3,
           next_4, next_5, next_6, next_7, status,
    input  ready
  );

  modport sink (
    input  valid, next_0, next_1, next_2, next_3,
           next_4, next_5, next_6, next_7, status,
    output ready
  );

endinterface

@@ rtl/next_digit_permutation_core.sv @@
// ----------------------------------------------------------------------------
// next_digit_permutation_core
// Next lexicographic permutation of a digit string, with status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries up to eight digits, most significant first, and digit_count
//   (a count above eight is taken as eight). out_ch returns the next
//   permutation; positions at or beyond the count read zero. status is 0 for
//   ok, 1 when a digit repeats, 2 when the digits are already fully
//   descending; in those two cases the digits pass through.
//   A transaction is taken when valid and ready are both high.
//   Throughput: one transaction per cycle while out_ch.ready is high; three
//   register stages (lane scan, merge with greater-than lanes, swap/reverse
//   select) hold one item each. Reset (rst, synchronous) empties all
//   stages; no item is in flight after. When out_ch.ready is low the result
//   holds and stages behind it keep filling; in_ch.ready drops once every
//   stage is occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module next_digit_permutation_core import ndp_pkg::*; (
  input logic      clk,
  input logic      rst,
  ndp_in_if.sink   in_ch,
  ndp_out_if.source out_ch
);

  digits_t                     d_in;
  cnt_t                        n_in;
  scan_flags_t [MAX_DIGITS-1:0] f_in;

  logic                        v1;
  digits_t                     d1;
  cnt_t                        n1;
  scan_flags_t [MAX_DIGITS-1:0] f1;
  merge_t                      m1;
  lane_vec_t                   gt1;

  logic                        v2;
  digits_t                     d2;
  cnt_t                        n2;
  merge_t                      m2;
  lane_vec_t                   gt2;
  pick_t                       k2;
  digits_t                     q2;

  logic                        v3;
  digits_t                     q3;
  status_t                     st3;

  logic                        adv1;
  logic                        adv2;
  logic                        adv3;

  // Stage advance: a stage moves when it is empty or the one ahead moves.
  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ch.ready = adv1;

  always_comb begin
    d_in[0] = in_ch.digit_0;
    d_in[1] = in_ch.digit_1;
    d_in[2] = in_ch.digit_2;
    d_in[3] = in_ch.digit_3;
    d_in[4] = in_ch.digit_4;
    d_in[5] = in_ch.digit_5;
    d_in[6] = in_ch.digit_6;
    d_in[7] = in_ch.digit_7;
    if (int'(in_ch.digit_count) > MAX_DIGITS) begin
      n_in = cnt_t'(MAX_DIGITS);
    end else begin
      n_in = cnt_t'(in_ch.digit_count);
    end
  end

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_scan
    ndp_scan_lane u_scan (
      .idx   (idx_t'(i)),
      .d     (d_in),
      .n     (n_in),
      .flags (f_in[i])
    );
  end

  ndp_merge u_merge (
    .flags (f1),
    .m     (m1)
  );

  // Lanes right of the ascent holding a larger digit.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      gt1[i] = (i > int'(m1.j)) && (i < int'(n1)) && (d1[i] > d1[m1.j]);
    end
  end

  assign k2 = last_set(gt2);

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_out
    ndp_out_lane u_out (
      .idx    (idx_t'(i)),
      .d      (d2),
      .n      (n2),
      .status (m2.status),
      .j      (m2.j),
      .k      (k2.idx),
      .q      (q2[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_ch.valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      d1 <= d_in;
      n1 <= n_in;
      f1 <= f_in;
    end
    if (adv2 && v1) begin
      d2  <= d1;
      n2  <= n1;
      m2  <= m1;
      gt2 <= gt1;
    end
    if (adv3 && v2) begin
      q3  <= q2;
      st3 <= m2.status;
    end
  end

  assign out_ch.valid  = v3;
  assign out_ch.next_0 = q3[0];
  assign out_ch.next_1 = q3[1];
  assign out_ch.next_2 = q3[2];
  assign out_ch.next_3 = q3[3];
  assign out_ch.next_4 = q3[4];
  assign out_ch.next_5 = q3[5];
  assign out_ch.next_6 = q3[6];
  assign out_ch.next_7 = q3[7];
  assign out_ch.status = st3;

  `ASSERT_NEXT(a_accept_fills_stage, clk, rst, in_ch.valid && in_ch.ready, v1, "accepted transaction lost at stage one")
  `ASSERT_IMPLY(a_ok_has_swap_partner, clk, rst, v2 && (m2.status == ST_OK), gt2 != '0, "ok status without a larger digit to swap")
  `ASSERT_IMPLY(a_ok_ascent_in_range, clk, rst, v2 && (m2.status == ST_OK), (int'(m2.j) + 1) < int'(n2), "ascent position outside digits in use")

endmodule

@@ rtl/ndp_scan_lane.sv @@
// ----------------------------------------------------------------------------
// ndp_scan_lane
// One digit position: ascent to the right neighbor and repeat detection.
// ----------------------------------------------------------------------------
module ndp_scan_lane import ndp_pkg::*; (
  input  idx_t        idx,
  input  digits_t     d,
  input  cnt_t        n,
  output scan_flags_t flags
);

  idx_t nxt;

  assign nxt = idx_t'(int'(idx) + 1);

  always_comb begin
    flags = '0;
    // nxt wraps on the last lane, but the count check masks it there
    flags.asc = ((int'(idx) + 1) < int'(n)) && (d[idx] < d[nxt]);
    for (int e = 0; e < MAX_DIGITS; e++) begin
      if ((e > int'(idx)) && (e < int'(n)) && (d[idx] == d[e])) begin
        flags.rep = 1'b1;
      end
    end
  end

endmodule

@@ rtl/ndp_merge.sv @@
// ----------------------------------------------------------------------------
// ndp_merge
// Combines lane flags into the status and the rightmost ascent position.
// ----------------------------------------------------------------------------
module ndp_merge import ndp_pkg::*; (
  input  scan_flags_t [MAX_DIGITS-1:0] flags,
  output merge_t                       m
);

  lane_vec_t asc_vec;
  lane_vec_t rep_vec;
  pick_t     pick;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      asc_vec[i] = flags[i].asc;
      rep_vec[i] = flags[i].rep;
    end
  end

  assign pick = last_set(asc_vec);

  always_comb begin
    m.j = pick.idx;
    if (|rep_vec) begin
      m.status = ST_REPEAT;
    end else if (!pick.found) begin
      m.status = ST_LAST;
    end else begin
      m.status = ST_OK;
    end
  end

endmodule

@@ rtl/ndp_out_lane.sv @@
// ----------------------------------------------------------------------------
// ndp_out_lane
// One result position: picks its digit after the swap and tail reversal.
// ----------------------------------------------------------------------------
module ndp_out_lane import ndp_pkg::*; (
  input  idx_t    idx,
  input  digits_t d,
  input  cnt_t    n,
  input  status_t status,
  input  idx_t    j,
  input  idx_t    k,
  output digit_t  q
);

  idx_t src;

  // Mirror position inside the reversed tail.
  assign src = idx_t'(int'(n) + int'(j) - int'(idx));

  always_comb begin
    if (int'(idx) >= int'(n)) begin
      q = '0;
    end else if ((status != ST_OK) || (idx < j)) begin
      q = d[idx];
    end else if (idx == j) begin
      q = d[k];
    end else if (src == k) begin
      q = d[j];
    end else begin
      q = d[src];
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for next_digit_permutation_core. A queue of digit
// strings (directed corner cases, then random ones, most of them free of
// repeats) feeds a clocked driver with bursty valid. A clocked receiver
// stalls out_ch on changing patterns, and a monitor checks each result, field
// by field, against a local next-permutation predictor.
// ----------------------------------------------------------------------------
module testbench;
  import ndp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 1950;
  localparam int CYCLE_LIMIT = 250000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT_FED = 700;
  localparam int SETTLE      = 12;

  typedef struct packed {
    logic                hold;   // wait for all results before presenting
    logic [CNT_IN_W-1:0] cnt;
    digits_t             digs;
  } perm_req_t;

  typedef struct packed {
    status_t status;
    digits_t digs;
  } perm_res_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic clk;
  logic rst;

  ndp_in_if  in_if();
  ndp_out_if out_if();

  next_digit_permutation_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  perm_req_t pending_perm_q[$];
  perm_res_t expected_next_q[$];

  perm_req_t cur_req;
  logic      drv_valid;
  int        burst_left;
  int        gap_left;
  int        n_fed;

  rx_mode_t  rx_mode;
  int        rx_mode_left;
  int        rx_tick;
  int        hold_left;
  bit        long_hold_done;
  logic      rx_ready;

  int        n_err;
  int        n_ok;
  int        n_repeat;
  int        n_last;
  int        cycles;

  // Next lexicographic permutation of the digits in use, with status.
  function automatic perm_res_t next_perm(perm_req_t r);
    perm_res_t res;
    digit_t    d [MAX_DIGITS];
    digit_t    t;
    int        n;
    int        piv;
    int        swp;
    int        lo;
    int        hi;
    n = (r.cnt > MAX_DIGITS) ? MAX_DIGITS : int'(r.cnt);
    for (int i = 0; i < MAX_DIGITS; i++) d[i] = r.digs[i];
    res.status = ST_OK;
    for (int i = 0; i < n; i++)
      for (int e = i + 1; e < n; e++)
        if (d[i] == d[e]) res.status = ST_REPEAT;
    if (res.status == ST_OK) begin
      piv = -1;
      for (int i = 0; i + 1 < n; i++)
        if (d[i] < d[i+1]) piv = i;
      if (piv < 0) begin
        res.status = ST_LAST;
      end else begin
        swp = piv + 1;
        for (int i = piv + 1; i < n; i++)
          if (d[i] > d[piv]) swp = i;
        t = d[piv];
        d[piv] = d[swp];
        d[swp] = t;
        lo = piv + 1;
        hi = n - 1;
        while (hi > lo) begin
          t = d[lo];
          d[lo] = d[hi];
          d[hi] = t;
          lo++;
          hi--;
        end
      end
    end
    for (int i = 0; i < MAX_DIGITS; i++) res.digs[i] = (i < n) ? d[i] : '0;
    return res;
  endfunction

  // Digit 0 sits in the top nibble of v.
  function automatic perm_req_t mk_req(logic [31:0] v, int cnt);
    perm_req_t r;
    r.hold = 1'b0;
    r.cnt  = CNT_IN_W'(cnt);
    for (int i = 0; i < MAX_DIGITS; i++) r.digs[i] = v[31-4*i -: 4];
    return r;
  endfunction

  function automatic perm_req_t rand_req();
    perm_req_t r;
    digit_t    pool [16];
    digit_t    t;
    int        kind;
    int        span;
    int        n;
    int        k;
    kind = $urandom_range(0, 99);
    span = (kind < 70) ? 10 : 16;
    for (int i = 0; i < 16; i++) pool[i] = digit_t'(i);
    for (int i = span - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[k];
      pool[k] = t;
    end
    n = $urandom_range(2, MAX_DIGITS);
    r.hold = 1'b0;
    r.cnt  = CNT_IN_W'(n);
    // positions past the count carry junk
    for (int i = 0; i < MAX_DIGITS; i++) r.digs[i] = digit_t'($urandom_range(0, 15));
    if (kind < 85) begin
      for (int i = 0; i < n; i++) r.digs[i] = pool[i];
      if (kind >= 80) begin
        // sort descending: already the last permutation
        for (int a = 0; a < n; a++)
          for (int b = 0; b + 1 < n - a; b++)
            if (r.digs[b] < r.digs[b+1]) begin
              t = r.digs[b];
              r.digs[b] = r.digs[b+1];
              r.digs[b+1] = t;
            end
      end
    end else if (kind < 95) begin
      for (int i = 0; i < n; i++) r.digs[i] = digit_t'($urandom_range(0, 9));
    end else begin
      r.cnt = CNT_IN_W'($urandom_range(0, 15));
    end
    return r;
  endfunction

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Driver: hold the item until taken, otherwise pull the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_next_q.push_back(next_perm(cur_req));
        n_fed++;
      end
      drv_valid = in_if.valid && !in_if.ready;
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_perm_q.size() > 0 &&
                     !(pending_perm_q[0].hold && expected_next_q.size() > 0)) begin
          cur_req   = pending_perm_q.pop_front();
          drv_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_if.valid       <= drv_valid;
      in_if.digit_0     <= cur_req.digs[0];
      in_if.digit_1     <= cur_req.digs[1];
      in_if.digit_2     <= cur_req.digs[2];
      in_if.digit_3     <= cur_req.digs[3];
      in_if.digit_4     <= cur_req.digs[4];
      in_if.digit_5     <= cur_req.digs[5];
      in_if.digit_6     <= cur_req.digs[6];
      in_if.digit_7     <= cur_req.digs[7];
      in_if.digit_count <= cur_req.cnt;
    end
  end

  // Receiver: stall pattern changes at random intervals; one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready   <= 1'b0;
      rx_mode        = RX_OPEN;
      rx_mode_left   = 0;
      rx_tick        = 0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else begin
      rx_tick++;
      if (!long_hold_done && n_fed >= HOLD_AT_FED) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_t'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 200);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          RX_OPEN:    rx_ready = 1'b1;
          RX_MOSTLY:  rx_ready = ($urandom_range(0, 3) != 0);
          RX_SPARSE:  rx_ready = ($urandom_range(0, 3) == 0);
          default:    rx_ready = ((rx_tick % 5) != 2) && ((rx_tick % 7) != 0);
        endcase
      end
      out_if.ready <= rx_ready;
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    perm_res_t want;
    digits_t   got_digs;
    if (!rst && out_if.valid && out_if.ready) begin
      got_digs = {out_if.next_7, out_if.next_6, out_if.next_5, out_if.next_4,
                  out_if.next_3, out_if.next_2, out_if.next_1, out_if.next_0};
      if (expected_next_q.size() == 0) begin
        $error("result with no expectation: status %0d", out_if.status);
        n_err++;
      end else begin
        want = expected_next_q.pop_front();
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (got_digs[i] !== want.digs[i]) begin
            $error("next_%0d: expected %0d, actual %0d", i, want.digs[i], got_digs[i]);
            n_err++;
          end
        end
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.status);
          n_err++;
        end
        case (want.status)
          ST_OK:     n_ok++;
          ST_REPEAT: n_repeat++;
          default:   n_last++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, expected_next_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    perm_req_t r;
    int        n_total;
    clk               = 1'b0;
    rst               = 1'b1;
    in_if.valid       = 1'b0;
    in_if.digit_0     = '0;
    in_if.digit_1     = '0;
    in_if.digit_2     = '0;
    in_if.digit_3     = '0;
    in_if.digit_4     = '0;
    in_if.digit_5     = '0;
    in_if.digit_6     = '0;
    in_if.digit_7     = '0;
    in_if.digit_count = '0;
    out_if.ready      = 1'b0;
    cur_req           = '0;
    n_fed             = 0;
    n_err             = 0;
    n_ok              = 0;
    n_repeat          = 0;
    n_last            = 0;
    cycles            = 0;

    pending_perm_q.push_back(mk_req(32'h0123_4567, 8));  // first in order
    pending_perm_q.push_back(mk_req(32'h7654_3210, 8));  // last in order
    pending_perm_q.push_back(mk_req(32'h9876_5432, 8));
    pending_perm_q.push_back(mk_req(32'h1584_7632, 8));
    pending_perm_q.push_back(mk_req(32'h1234_5671, 8));  // repeat at both ends
    pending_perm_q.push_back(mk_req(32'h5532_1000, 8));  // repeat wins over descending
    pending_perm_q.push_back(mk_req(32'hFFFF_FFFF, 8));
    pending_perm_q.push_back(mk_req(32'h0000_0000, 8));
    pending_perm_q.push_back(mk_req(32'h1200_0000, 2));
    pending_perm_q.push_back(mk_req(32'h2100_0000, 2));
    pending_perm_q.push_back(mk_req(32'h3AAA_AAAA, 0));  // empty string
    pending_perm_q.push_back(mk_req(32'h5FFF_FFFF, 1));  // single digit
    pending_perm_q.push_back(mk_req(32'h0123_4567, 15)); // count saturates
    pending_perm_q.push_back(mk_req(32'h9875_4321, 9));
    pending_perm_q.push_back(mk_req(32'hFEDC_BA98, 8));  // digits above nine
    pending_perm_q.push_back(mk_req(32'hABCD_EF98, 6));
    pending_perm_q.push_back(mk_req(32'h1233_FFFF, 3));  // repeat past the count
    pending_perm_q.push_back(mk_req(32'h2310_7777, 4));
    pending_perm_q.push_back(mk_req(32'h0F1E_2D3C, 8));
    pending_perm_q.push_back(mk_req(32'h9012_3456, 7));
    pending_perm_q.push_back(mk_req(32'h89AB_CDEF, 8));
    pending_perm_q.push_back(mk_req(32'hFED0_1234, 3));

    for (int i = 0; i < N_RANDOM; i++) begin
      r = rand_req();
      if (i == 1000 || i == 1700) r.hold = 1'b1;
      pending_perm_q.push_back(r);
    end
    n_total = pending_perm_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // wait until every item is taken and every result checked
    while (n_fed < n_total || expected_next_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Fed %0d strings; results: %0d next permutations, %0d repeated digit, %0d last",
             n_fed, n_ok, n_repeat, n_last);
    $display("Traffic ran with bursty input, mixed output stalls and a %0d-cycle hold-off",
             LONG_HOLD);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ndp_pkg.sv
rtl/ndp_in_if.sv
rtl/ndp_out_if.sv
rtl/ndp_scan_lane.sv
rtl/ndp_merge.sv
rtl/ndp_out_lane.sv
rtl/next_digit_permutation_core.sv
verif/testbench.sv
